@@ src/wsdq_pkg.sv @@
// Package for the work stealing deque unit: command and status codes and the
// per-item result record passed from the counter logic to the output stage.
// No dependencies.
package wsdq_pkg;

	typedef enum logic [1:0] {
		CMD_PUSH  = 2'd0,
		CMD_POP   = 2'd1,
		CMD_STEAL = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Outcome of one command, known in the cycle the command is accepted.
	typedef struct packed {
		status_t status;
		logic    take;
		logic    is_empty;
		logic    is_full;
	} result_t;

endpackage

@@ src/wsdq_ctrl.sv @@
// Bottom and top counters of the deque and the decision logic for one command.
// Depends on wsdq_pkg.
module wsdq_ctrl
	import wsdq_pkg::*;
#(
	parameter int DEPTH = 128
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       step,
	input  logic [1:0]                 command,
	output logic [$clog2(DEPTH)-1:0]   slot,
	output logic                       wr_en,
	output logic                       rd_en,
	output result_t                    result
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = AW + 1;
	localparam logic [CW-1:0] ONE      = CW'(1);
	localparam logic [CW-1:0] FULL_XOR = CW'(DEPTH);

	logic [CW-1:0] bottom_q;
	logic [CW-1:0] top_q;
	logic [CW-1:0] bottom_d;
	logic [CW-1:0] top_d;
	logic [CW-1:0] bottom_dec;
	logic          empty_now;
	logic          full_now;
	status_t       status;
	logic          take;

	assign bottom_dec = bottom_q - ONE;
	assign empty_now  = (bottom_q == top_q) || ((bottom_q + ONE) == top_q);
	assign full_now   = (bottom_q ^ top_q) == FULL_XOR;

	always_comb begin
		bottom_d = bottom_q;
		top_d    = top_q;
		status   = ST_DONE;
		take     = 1'b0;
		wr_en    = 1'b0;
		slot     = bottom_q[AW-1:0];
		unique case (cmd_t'(command))
			CMD_PUSH: begin
				if (full_now) begin
					status = ST_FULL;
				end else begin
					wr_en    = 1'b1;
					bottom_d = bottom_q + ONE;
				end
			end
			CMD_POP: begin
				slot = bottom_dec[AW-1:0];
				if (bottom_q == top_q) begin
					// Nothing to pop: bottom snaps back onto top.
					bottom_d = top_q;
					status   = ST_EMPTY;
				end else begin
					take = 1'b1;
					if (bottom_dec != top_q) begin
						bottom_d = bottom_dec;
					end else begin
						// Last task: claim it through top, then rejoin bottom to top.
						top_d    = top_q + ONE;
						bottom_d = top_q + ONE;
					end
				end
			end
			CMD_STEAL: begin
				slot = top_q[AW-1:0];
				if (empty_now) begin
					status = ST_EMPTY;
				end else begin
					take  = 1'b1;
					top_d = top_q + ONE;
				end
			end
			default: begin
			end
		endcase
	end

	assign rd_en           = step && take;
	assign result.status   = status;
	assign result.take     = take;
	assign result.is_empty = (bottom_d == top_d) || ((bottom_d + ONE) == top_d);
	assign result.is_full  = (bottom_d ^ top_d) == FULL_XOR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bottom_q <= '0;
			top_q    <= '0;
		end else if (step) begin
			bottom_q <= bottom_d;
			top_q    <= top_d;
		end
	end

endmodule

@@ src/wsdq_store.sv @@
// Task store of the deque: one-port memory with registered read data and a
// written flag per slot so that never-written slots read as zero.
// No dependencies.
module wsdq_store #(
	parameter int DEPTH      = 128,
	parameter int TASK_WIDTH = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [$clog2(DEPTH)-1:0] slot,
	input  logic                     wr_en,
	input  logic [TASK_WIDTH-1:0]    wr_data,
	input  logic                     rd_en,
	output logic [TASK_WIDTH-1:0]    rd_data
);

	logic [TASK_WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0]      written_q;
	logic [TASK_WIDTH-1:0] rd_raw_q;
	logic                  rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[slot] <= 1'b1;
			end
			if (rd_en) begin
				rd_written_q <= written_q[slot];
			end
		end
	end

	assign rd_data = rd_written_q ? rd_raw_q : '0;

endmodule

@@ src/work_stealing_deque_unit.sv @@
// Work stealing deque unit: fixed-size double-ended task queue, one command per beat.
// The result beat is registered: it is offered in the cycle after its command beat is accepted.
// Throughput: one command per cycle while results are taken; the result register frees as its beat is taken.
// Reset (arst_n, asynchronous, active low) empties the queue: both counters go to
// zero and every slot reads as zero until written. No clearing pass is needed.
// Depends on wsdq_pkg, wsdq_ctrl and wsdq_store.
module work_stealing_deque_unit
	import wsdq_pkg::*;
#(
	parameter int DEPTH      = 128,
	parameter int TASK_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [1:0]            command,
	input  logic [TASK_WIDTH-1:0] task_in,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            status,
	output logic [TASK_WIDTH-1:0] task_out,
	output logic                  is_empty,
	output logic                  is_full
);

	localparam int AW = $clog2(DEPTH);

	logic                  step;
	logic [AW-1:0]         slot;
	logic                  wr_en;
	logic                  rd_en;
	result_t               result;
	result_t               result_s1;
	logic                  valid_s1;
	logic [TASK_WIDTH-1:0] rd_data;

	// A command beat is taken whenever the result register is empty or its
	// beat leaves in the same cycle, so the deque runs at one command a cycle
	// even while results are flowing out.
	assign in_ready = !valid_s1 || out_ready;
	assign step     = in_valid && in_ready;

	// Counter logic decides the whole command in the accept cycle; the counters
	// update at that edge so the next command sees the new bottom and top.
	wsdq_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.command (command),
		.slot    (slot),
		.wr_en   (wr_en),
		.rd_en   (rd_en),
		.result  (result)
	);

	// Push writes at the accept edge; pop and steal load the read register at
	// that same edge, so the task taken lines up with the result register.
	// A read register that is only loaded on a take holds its value under stall.
	wsdq_store #(
		.DEPTH      (DEPTH),
		.TASK_WIDTH (TASK_WIDTH)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.slot    (slot),
		.wr_en   (step && wr_en),
		.wr_data (task_in),
		.rd_en   (rd_en),
		.rd_data (rd_data)
	);

	// Result register: holds status and flags of the command in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			result_s1 <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			if (in_valid) begin
				result_s1 <= result;
			end
		end
	end

	assign out_valid = valid_s1;
	assign status    = result_s1.status;
	assign task_out  = result_s1.take ? rd_data : '0;
	assign is_empty  = result_s1.is_empty;
	assign is_full   = result_s1.is_full;

endmodule

@@ test/wsdq_test_pkg.sv @@
// Shadow model and result checker for the work stealing deque unit testbench.
// Depends on wsdq_pkg for the command and status codes.
package wsdq_test_pkg;
	import wsdq_pkg::*;

	// The command encoding leaves one value unused; the unit must treat it as a no-op.
	localparam logic [1:0] CMD_NONE = 2'd3;
	localparam int QUEUE_DEPTH = 128;

	typedef struct {
		status_t     status;
		logic [31:0] handle;
		logic        empty_flag;
		logic        full_flag;
	} deque_result_t;

	class task_deque_tracker;
		logic [7:0]    bottom_cnt;
		logic [7:0]    top_cnt;
		logic [31:0]   slots [QUEUE_DEPTH];
		deque_result_t awaited [$];
		int            errors;
		int            noted;
		int            checked;
		int            refused_pushes;
		int            empty_takes;
		int            last_pops;

		function new();
			bottom_cnt     = '0;
			top_cnt        = '0;
			foreach (slots[i])
				slots[i] = '0;
			errors         = 0;
			noted          = 0;
			checked        = 0;
			refused_pushes = 0;
			empty_takes    = 0;
			last_pops      = 0;
		endfunction

		function bit drained();
			logic [7:0] next_bottom;
			next_bottom = bottom_cnt + 8'd1;
			return (bottom_cnt == top_cnt) || (next_bottom == top_cnt);
		endfunction

		function bit at_capacity();
			return (bottom_cnt ^ top_cnt) == 8'(QUEUE_DEPTH);
		endfunction

		// Applies one accepted command to the shadow deque and queues its result.
		function void note_command(logic [1:0] cmd, logic [31:0] handle_in);
			deque_result_t r;
			logic [7:0]    b;
			logic [7:0]    b_next;
			r.status = ST_DONE;
			r.handle = '0;
			noted++;
			case (cmd)
				CMD_PUSH: begin
					if (at_capacity()) begin
						r.status = ST_FULL;
						refused_pushes++;
					end else begin
						slots[bottom_cnt[6:0]] = handle_in;
						bottom_cnt = bottom_cnt + 8'd1;
					end
				end
				CMD_POP: begin
					b      = bottom_cnt - 8'd1;
					b_next = b + 8'd1;
					if (b_next == top_cnt) begin
						bottom_cnt = top_cnt;
						r.status   = ST_EMPTY;
						empty_takes++;
					end else begin
						r.handle = slots[b[6:0]];
						if (b != top_cnt) begin
							bottom_cnt = b;
						end else begin
							// Taking the last task moves top past it as well.
							top_cnt    = top_cnt + 8'd1;
							bottom_cnt = top_cnt;
							last_pops++;
						end
					end
				end
				CMD_STEAL: begin
					if (drained()) begin
						r.status = ST_EMPTY;
						empty_takes++;
					end else begin
						r.handle = slots[top_cnt[6:0]];
						top_cnt  = top_cnt + 8'd1;
					end
				end
				default: ;
			endcase
			r.empty_flag = drained();
			r.full_flag  = at_capacity();
			awaited.push_back(r);
		endfunction

		function void check_result(logic [1:0] st, logic [31:0] handle_out, logic e, logic f,
				longint unsigned now);
			deque_result_t r;
			if (awaited.size() == 0) begin
				errors++;
				$display("%0d ns: result beat with no command pending: status %0d task %h",
					now, st, handle_out);
				return;
			end
			r = awaited.pop_front();
			checked++;
			if (st !== r.status) begin
				errors++;
				$display("%0d ns: status expected %0d actual %0d", now, r.status, st);
			end
			if (handle_out !== r.handle) begin
				errors++;
				$display("%0d ns: task_out expected %h actual %h", now, r.handle, handle_out);
			end
			if (e !== r.empty_flag) begin
				errors++;
				$display("%0d ns: is_empty expected %0b actual %0b", now, r.empty_flag, e);
			end
			if (f !== r.full_flag) begin
				errors++;
				$display("%0d ns: is_full expected %0b actual %0b", now, r.full_flag, f);
			end
		endfunction
	endclass

endpackage

@@ test/work_stealing_deque_unit_test.sv @@
// Self-checking testbench for work_stealing_deque_unit: directed and random command beats.
// Depends on wsdq_pkg, wsdq_test_pkg and the unit itself.
module work_stealing_deque_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import wsdq_pkg::*;
	import wsdq_test_pkg::*;

	localparam int RANDOM_ITEMS    = 2000;
	localparam int PHASE_COUNT     = 4;
	localparam int SEGMENT_ITEMS   = 200;
	localparam int HOLD_OFF_CYCLES = 300;
	// The longest legitimate quiet stretch is the hold-off plus a few random stalls.
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRAIN_CYCLES    = 10;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [1:0]  command;
	logic [31:0] task_in;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] task_out;
	logic        is_empty;
	logic        is_full;

	// Traffic shaping knobs, in percent of cycles, changed between phases.
	int idle_pct      = 0;
	int stall_pct     = 0;
	// A long receiver hold-off is requested here and counted down by the receiver.
	int hold_request  = 0;
	int hold_left     = 0;
	int quiet_cycles  = 0;
	int input_stalls  = 0;

	task_deque_tracker sb;

	work_stealing_deque_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.task_in   (task_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.task_out  (task_out),
		.is_empty  (is_empty),
		.is_full   (is_full)
	);

	always #5 clk = ~clk;

	// Offers one command beat. It is entered just after a falling edge and returns just
	// after the falling edge that follows acceptance, with in_valid still high, so the
	// next call is the only place that may change in_valid in that time step.
	task automatic offer_command(input logic [1:0] cmd, input logic [31:0] handle);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		task_in  <= handle;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	// Receiver: random back-pressure, or a long hold-off when one has been requested.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Monitor: both channels are sampled at the rising edge in one process, so a command
	// is always recorded before any result that it could cause is checked. The same
	// process runs the watchdog on cycles where neither channel moves a beat.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				sb.note_command(command, task_in);
			if (out_valid && out_ready)
				sb.check_result(status, task_out, is_empty, is_full, $time);
			if (in_valid && !in_ready)
				input_stalls++;
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= WATCHDOG_LIMIT) begin
					$display("Watchdog: no beat moved for %0d cycles at %0d ns",
						quiet_cycles, $time);
					$display("work_stealing_deque_unit regression: fail");
					$finish;
				end
			end
		end
	end

	initial begin
		int          idle_by_phase [PHASE_COUNT];
		int          stall_by_phase [PHASE_COUNT];
		int          push_bias;
		int          roll;
		int          pick;
		logic [1:0]  cmd;
		logic [31:0] handle;

		idle_by_phase  = '{0, 73, 0, 21};
		stall_by_phase = '{0, 0, 73, 21};
		push_bias      = 50;
		sb             = new();

		// Every input is known from time zero, with reset asserted; reset is released at a falling edge.
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		command   = CMD_PUSH;
		task_in   = '0;
		out_ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Directed part. Taking from the freshly reset queue must report it empty,
		// and the unused command value must change nothing.
		offer_command(CMD_STEAL, 32'h0000_0000);
		offer_command(CMD_POP, 32'hFFFF_FFFF);
		offer_command(CMD_NONE, 32'h1234_5678);
		// Extreme handles go in, then come back out from both ends.
		offer_command(CMD_PUSH, 32'h0000_0000);
		offer_command(CMD_PUSH, 32'hFFFF_FFFF);
		offer_command(CMD_PUSH, 32'h5A5A_A5A5);
		offer_command(CMD_POP, 32'h0000_0000);
		offer_command(CMD_STEAL, 32'h0000_0000);
		// A steal that takes the only remaining task leaves the queue empty.
		offer_command(CMD_STEAL, 32'h0000_0000);
		offer_command(CMD_STEAL, 32'h0000_0000);
		// A pop that takes the last task advances top and pulls bottom along with it.
		offer_command(CMD_PUSH, 32'hA5A5_5A5A);
		offer_command(CMD_POP, 32'h0000_0000);
		offer_command(CMD_POP, 32'h0000_0000);
		offer_command(CMD_PUSH, 32'h8000_0001);
		offer_command(CMD_PUSH, 32'h7FFF_FFFE);
		offer_command(CMD_PUSH, 32'h0F0F_F0F0);
		offer_command(CMD_NONE, 32'hFFFF_FFFF);
		offer_command(CMD_STEAL, 32'h0000_0000);
		offer_command(CMD_POP, 32'h0000_0000);
		offer_command(CMD_POP, 32'h0000_0000);
		offer_command(CMD_STEAL, 32'h0000_0000);

		// The receiver now holds off for a long stretch while commands keep coming,
		// so the result register fills and in_ready has to drop.
		hold_request = HOLD_OFF_CYCLES;

		// Random part. Within each phase the push share switches every segment between
		// filling, draining and balanced traffic, so the queue repeatedly runs full
		// and runs dry with random handles in between.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			idle_pct  = idle_by_phase[p];
			stall_pct = stall_by_phase[p];
			for (int n = 0; n < RANDOM_ITEMS / PHASE_COUNT; n++) begin
				if (n % SEGMENT_ITEMS == 0) begin
					case ($urandom_range(2))
						0: push_bias = 95;
						1: push_bias = 10;
						default: push_bias = 50;
					endcase
				end
				roll = $urandom_range(99);
				if (roll < 2)
					cmd = CMD_NONE;
				else if (roll < push_bias)
					cmd = CMD_PUSH;
				else if ($urandom_range(1) == 1)
					cmd = CMD_POP;
				else
					cmd = CMD_STEAL;
				pick = $urandom_range(9);
				if (pick == 0)
					handle = '0;
				else if (pick == 1)
					handle = '1;
				else
					handle = $urandom();
				offer_command(cmd, handle);
			end
		end
		in_valid <= 1'b0;
		stall_pct = 0;

		// Wait for every outstanding result, then a short margin for stray beats.
		while (sb.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d commands and checked %0d result beats over four traffic phases;",
			sb.noted, sb.checked);
		$display("%0d refused pushes, %0d empty takes, %0d last-task pops, %0d input stalls.",
			sb.refused_pushes, sb.empty_takes, sb.last_pops, input_stalls);
		if (sb.errors == 0 && sb.awaited.size() == 0) begin
			$display("work_stealing_deque_unit regression: pass");
		end else begin
			$display("work_stealing_deque_unit regression: fail");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/wsdq_pkg.sv
src/wsdq_ctrl.sv
src/wsdq_store.sv
src/work_stealing_deque_unit.sv
test/wsdq_test_pkg.sv
test/work_stealing_deque_unit_test.sv
